FILE: hw/rtl/bwe_pkg.sv
// ----------------------------------------------------------------------------
// bwe_pkg
// Shared types, constants and bit-step functions for the crc-24 and
// whitening encoder.
// ----------------------------------------------------------------------------
package bwe_pkg;

  localparam int unsigned CRC_W       = 24;
  localparam int unsigned CHAN_W      = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CRC_W-1:0]  CRC_POLY      = 24'h00065B;
  localparam logic [CRC_W-1:0]  CRC_INIT_RST  = 24'h555555;
  localparam logic [CHAN_W-1:0] WHITEN_CH_RST = 6'd39;
  localparam logic [BYTE_W-1:0] WHITEN_TAP    = 8'h11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WHITEN_CHANNEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CRC_INIT       = 1'd1;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_MID,
    PH_CRC_LO
  } bwe_phase_t;

  // one queued pdu byte with the crc value after it
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [CRC_W-1:0]  crc;
  } bwe_entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] lfsr;
    logic [BYTE_W-1:0] mask;
  } bwe_whiten_t;

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

  // channel bit-reversed into bits 7..2, bit 1 set, bit 0 clear
  function automatic logic [BYTE_W-1:0] whiten_seed(input logic [CHAN_W-1:0] ch);
    return {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], 1'b1, 1'b0};
  endfunction

  // eight lsb-first crc steps
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    logic             top;
    c = c_in;
    for (int i = 0; i < BYTE_W; i++) begin
      top = c[CRC_W-1];
      c   = {c[CRC_W-2:0], 1'b0};
      if (d[i] != top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // eight lfsr steps, mask bit i is the whitening bit for data bit i
  function automatic bwe_whiten_t whiten_byte(input logic [BYTE_W-1:0] r_in);
    bwe_whiten_t w;
    logic [BYTE_W-1:0] r;
    r = r_in;
    w.mask = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      w.mask[i] = r[BYTE_W-1];
      if (r[BYTE_W-1]) begin
        r = r ^ WHITEN_TAP;
      end
      r = {r[BYTE_W-2:0], 1'b0};
    end
    w.lfsr = r;
    return w;
  endfunction

endpackage

FILE: hw/rtl/bwe_if.sv
// ----------------------------------------------------------------------------
// bwe_in_if / bwe_out_if
// Valid/ready channels for pdu bytes in and encoded bytes out.
// ----------------------------------------------------------------------------
interface bwe_in_if;
  logic                     valid;
  logic                     ready;
  logic [bwe_pkg::BYTE_W-1:0] data_byte;
  logic                     last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bwe_out_if;
  logic                     valid;
  logic                     ready;
  logic [bwe_pkg::BYTE_W-1:0] out_byte;
  logic                     is_crc;
  logic                     end_of_packet;

  modport source (output valid, output out_byte, output is_crc, output end_of_packet,
                  input ready);
  modport sink   (input valid, input out_byte, input is_crc, input end_of_packet,
                  output ready);
endinterface

FILE: hw/rtl/bwe_front.sv
// ----------------------------------------------------------------------------
// bwe_front
// Accepts pdu bytes, tracks packet boundaries and runs the crc-24.
// ----------------------------------------------------------------------------
module bwe_front (
  input  logic                        clk,
  input  logic                        rst_n,
  bwe_in_if.sink                      in_if,
  input  logic [bwe_pkg::CRC_W-1:0]   crc_init,
  output logic                        push_valid,
  input  logic                        push_ready,
  output bwe_pkg::bwe_entry_t         push_entry
);

  logic                      start_r;
  logic [bwe_pkg::CRC_W-1:0] crc_r;
  logic [bwe_pkg::CRC_W-1:0] crc_base;
  logic [bwe_pkg::CRC_W-1:0] crc_nxt;
  logic                      accept;

  assign in_if.ready = push_ready;
  assign push_valid  = in_if.valid;
  assign accept      = in_if.valid && push_ready;

  // crc reloads on the first byte of every packet
  assign crc_base = start_r ? crc_init : crc_r;
  assign crc_nxt  = bwe_pkg::crc_byte(crc_base, in_if.data_byte);

  always_comb begin
    push_entry.data_byte = in_if.data_byte;
    push_entry.last_byte = in_if.last_byte;
    push_entry.crc       = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
    end else if (accept) begin
      start_r <= in_if.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      crc_r <= crc_nxt;
    end
  end

endmodule

FILE: hw/rtl/bwe_fifo.sv
// ----------------------------------------------------------------------------
// bwe_fifo
// Short queue between the crc front and the whitening back end.
// ----------------------------------------------------------------------------
module bwe_fifo #(
  parameter int unsigned DEPTH = bwe_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  bwe_pkg::bwe_entry_t push_entry,
  output logic                head_valid,
  input  logic                head_pop,
  output bwe_pkg::bwe_entry_t head_entry
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bwe_pkg::bwe_entry_t mem_r [DEPTH];
  logic [AW-1:0]       wr_ptr_r;
  logic [AW-1:0]       rd_ptr_r;
  logic [CW-1:0]       cnt_r;
  logic                push;
  logic                pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue count missed a push");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("queue count missed a pop");
`endif

endmodule

FILE: hw/rtl/bwe_back.sv
// ----------------------------------------------------------------------------
// bwe_back
// Whitens queued pdu bytes and appends the three crc bytes after the last.
// ----------------------------------------------------------------------------
module bwe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bwe_pkg::CHAN_W-1:0]  whiten_channel,
  input  logic                        head_valid,
  output logic                        head_pop,
  input  bwe_pkg::bwe_entry_t         head_entry,
  bwe_out_if.source                   out_if
);

  bwe_pkg::bwe_phase_t        ph_r;
  bwe_pkg::bwe_phase_t        ph_nxt;
  logic                       start_r;
  logic [bwe_pkg::BYTE_W-1:0] lfsr_r;
  logic                       out_valid_r;
  logic [bwe_pkg::BYTE_W-1:0] out_byte_r;
  logic                       is_crc_r;
  logic                       eop_r;

  logic                       adv;
  logic                       done;
  logic [bwe_pkg::BYTE_W-1:0] raw_byte;
  logic                       sel_crc;
  logic                       sel_eop;
  logic [bwe_pkg::BYTE_W-1:0] lfsr_base;
  bwe_pkg::bwe_whiten_t       ws;

  // the output register frees up when empty or taken this cycle
  assign adv      = head_valid && (!out_valid_r || out_if.ready);
  assign head_pop = adv && done;

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      bwe_pkg::PH_DATA: begin
        if (adv && head_entry.last_byte) ph_nxt = bwe_pkg::PH_CRC_HI;
      end
      bwe_pkg::PH_CRC_HI: begin
        if (adv) ph_nxt = bwe_pkg::PH_CRC_MID;
      end
      bwe_pkg::PH_CRC_MID: begin
        if (adv) ph_nxt = bwe_pkg::PH_CRC_LO;
      end
      bwe_pkg::PH_CRC_LO: begin
        if (adv) ph_nxt = bwe_pkg::PH_DATA;
      end
      default: ph_nxt = bwe_pkg::PH_DATA;
    endcase
  end

  always_comb begin
    raw_byte = head_entry.data_byte;
    sel_crc  = 1'b0;
    sel_eop  = 1'b0;
    done     = 1'b0;
    unique case (ph_r)
      bwe_pkg::PH_DATA: begin
        done = !head_entry.last_byte;
      end
      bwe_pkg::PH_CRC_HI: begin
        raw_byte = bwe_pkg::rev8(head_entry.crc[23:16]);
        sel_crc  = 1'b1;
      end
      bwe_pkg::PH_CRC_MID: begin
        raw_byte = bwe_pkg::rev8(head_entry.crc[15:8]);
        sel_crc  = 1'b1;
      end
      bwe_pkg::PH_CRC_LO: begin
        raw_byte = bwe_pkg::rev8(head_entry.crc[7:0]);
        sel_crc  = 1'b1;
        sel_eop  = 1'b1;
        done     = 1'b1;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // lfsr reseeds from the channel on the first byte of a packet
  assign lfsr_base = start_r ? bwe_pkg::whiten_seed(whiten_channel) : lfsr_r;
  assign ws        = bwe_pkg::whiten_byte(lfsr_base);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= bwe_pkg::PH_DATA;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (adv) begin
        start_r     <= (ph_r == bwe_pkg::PH_CRC_LO);
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lfsr_r     <= ws.lfsr;
      out_byte_r <= raw_byte ^ ws.mask;
      is_crc_r   <= sel_crc;
      eop_r      <= sel_eop;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_byte      = out_byte_r;
  assign out_if.is_crc        = is_crc_r;
  assign out_if.end_of_packet = eop_r;

`ifndef NO_ASSERTIONS
  a_eop_is_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && eop_r) |-> is_crc_r)
    else $error("end of packet on a non-crc byte");

  a_reseed_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ph_r == bwe_pkg::PH_CRC_LO) |=> start_r)
    else $error("lfsr not reseeded after crc tail");

  a_tail_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ph_r != bwe_pkg::PH_DATA) |=> (out_valid_r && is_crc_r))
    else $error("crc byte not flagged");
`endif

endmodule

FILE: hw/rtl/ble_crc24_whitening_encoder.sv
// ----------------------------------------------------------------------------
// ble_crc24_whitening_encoder
// Link-layer crc-24 and data whitening for one pdu byte stream.
// ----------------------------------------------------------------------------
// One pdu byte is accepted per cycle while the queue has room. The front runs
// the crc over each byte in the accepting cycle and queues it; the back end
// whitens and emits one byte per cycle through an output register while the
// output is not stalled, and a byte marked last is followed by the three
// bit-reversed crc bytes, high byte first. Each byte passes through the queue
// and then the output register on its way to the output port. Crc and lfsr
// reload from the configuration registers at every packet start;
// configuration is written with cfg_we, cfg_index and cfg_wdata.
// ----------------------------------------------------------------------------
module ble_crc24_whitening_encoder #(
  parameter int unsigned QUEUE_DEPTH = bwe_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bwe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  bwe_in_if.sink                           in_if,
  bwe_out_if.source                        out_if
);

  logic [bwe_pkg::CHAN_W-1:0] whiten_channel_r;
  logic [bwe_pkg::CRC_W-1:0]  crc_init_r;

  logic                push_valid;
  logic                push_ready;
  bwe_pkg::bwe_entry_t push_entry;
  logic                head_valid;
  logic                head_pop;
  bwe_pkg::bwe_entry_t head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whiten_channel_r <= bwe_pkg::WHITEN_CH_RST;
      crc_init_r       <= bwe_pkg::CRC_INIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bwe_pkg::CFG_IDX_WHITEN_CHANNEL: whiten_channel_r <= cfg_wdata[bwe_pkg::CHAN_W-1:0];
        bwe_pkg::CFG_IDX_CRC_INIT:       crc_init_r       <= cfg_wdata[bwe_pkg::CRC_W-1:0];
        default: ;
      endcase
    end
  end

  bwe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .crc_init   (crc_init_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  bwe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_entry (head_entry)
  );

  bwe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .whiten_channel (whiten_channel_r),
    .head_valid     (head_valid),
    .head_pop       (head_pop),
    .head_entry     (head_entry),
    .out_if         (out_if)
  );

endmodule
